// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file of the report aggregation buffer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising edge of clk outside reset.
`define RAB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define RAB_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

// ----- src/rab_pkg.sv -----
// Types and constants shared by the report aggregation buffer modules.
package rab_pkg;

	// Request operation codes.
	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Result kinds.
	localparam logic [2:0] KIND_FLUSHED = 3'd0;
	localparam logic [2:0] KIND_POOL    = 3'd1;
	localparam logic [2:0] KIND_NOROUTE = 3'd2;
	localparam logic [2:0] KIND_NBRFULL = 3'd3;
	localparam logic [2:0] KIND_DROPPED = 3'd4;

	// Occupancy percent: the quotient stays below 100, so seven bits suffice.
	localparam int QUOT_W     = 7;
	localparam int DIVIDEND_W = 15;
	localparam logic [DIVIDEND_W-1:0] PERCENT = 15'd100;
	localparam logic [7:0] CAP_RESET = 8'd8;

	typedef struct packed {
		logic        op;
		logic [7:0]  origin;
		logic [15:0] seq;
		logic        pool_full;
		logic        has_route;
		logic        nbr_known;
		logic [7:0]  nbr_fill;
	} rab_req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [4:0]  frame_count;
		logic [7:0]  rep_origin;
		logic [15:0] rep_seq;
		logic        last;
		logic [6:0]  occupancy_avg;
	} rab_rsp_t;

	typedef struct packed {
		logic [7:0]  origin;
		logic [15:0] seq;
	} rab_report_t;

	// Per-cell control: load the new report, or take the neighbor's report.
	typedef struct packed {
		logic load;
		logic shift;
	} rab_cell_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEFER,
		ST_DROP,
		ST_DIV,
		ST_EWMA,
		ST_EMIT,
		ST_APPEND
	} rab_state_t;

endpackage

// ----- src/rab_cell.sv -----
// One storage cell of the report chain, shifting toward the head on request.
module rab_cell (
	input  logic                    clk,
	input  rab_pkg::rab_cell_ctrl_t ctrl,
	input  rab_pkg::rab_report_t    load_data,
	input  rab_pkg::rab_report_t    nbr_data,
	output rab_pkg::rab_report_t    data
);
	import rab_pkg::*;

	rab_report_t data_q;

	// A load takes the new report; a shift takes the report of the next cell.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= load_data;
		end else if (ctrl.shift) begin
			data_q <= nbr_data;
		end
	end

	assign data = data_q;

endmodule

// ----- src/rab_div.sv -----
// Restoring divider that yields the occupancy percent one quotient bit per cycle.
module rab_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [rab_pkg::DIVIDEND_W-1:0] dividend,
	input  logic [7:0]                     divisor,
	output logic                           done,
	output logic [rab_pkg::QUOT_W-1:0]     quotient
);
	import rab_pkg::*;

	localparam int STEP_W = $clog2(QUOT_W);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     step_q;
	logic [DIVIDEND_W-1:0] rem_q;
	logic [DIVIDEND_W-1:0] dvs_q;
	logic [QUOT_W-1:0]     quot_q;
	logic                  fits;

	assign fits = (rem_q >= dvs_q);

	// Sequencing: QUOT_W steps after start, then a one-cycle done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	// Datapath: trial subtract of the divisor aligned to the current bit.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			dvs_q  <= DIVIDEND_W'(divisor) << (QUOT_W - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dvs_q;
			end
			quot_q <= {quot_q[QUOT_W-2:0], fits};
			dvs_q  <= dvs_q >> 1;
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

// ----- src/report_aggregation_buffer.sv -----
// Report aggregation buffer: top level with the cell chain, control and result register.
//
// Reports are held oldest first in a row of MAX_ITEMS cells. An add with room is stored
// as it is accepted and the block stays ready. A flush (a tick on a non-empty buffer,
// or an add on a full one) that goes ahead is accepted, runs the occupancy divider when
// the neighbor queue is known, updates the average, and then emits one report per cycle
// unless the result side stalls, as the chain shifts each report out of its head
// cell; an add that caused it then stores the new report. A deferral emits its result,
// and a deferred add then drops the oldest report and stores the new one. Results wait
// in one output register, so a stalled result side holds the block until the result is
// taken. The cells need no clearing after reset; an entry is read only once written.
module report_aggregation_buffer #(
	parameter int MAX_ITEMS = 24,
	parameter int AVG_SHIFT = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  rab_pkg::rab_req_t req_data,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rab_pkg::rab_rsp_t rsp_data,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata
);
	import rab_pkg::*;

	localparam int CW = $clog2(MAX_ITEMS + 1);

	rab_state_t     state_q, state_nxt;
	logic [CW-1:0]  cnt_q;
	logic [CW-1:0]  frame_q;
	logic [7:0]     cap_q;
	logic [6:0]     ewma_q;
	logic           op_q;
	logic           known_q;
	logic [2:0]     kind_q;
	rab_report_t    rep_q;
	rab_rsp_t       rsp_q;
	logic           rsp_valid_q;

	logic           req_acc;
	logic           rsp_free;
	logic           full;
	logic           defer_hit;
	logic [2:0]     defer_kind;
	logic           rsp_load;
	rab_rsp_t       rsp_nxt;
	logic           shift;
	logic           append;
	logic           div_start;
	logic           div_done;
	logic [QUOT_W-1:0] div_quot;
	logic           ewma_load;
	rab_report_t    new_rep;
	rab_report_t    load_rep;

	logic [QUOT_W-1:0] occ;
	logic signed [8:0] ewma_diff;
	logic signed [8:0] ewma_step;
	logic signed [8:0] ewma_sum;

	rab_report_t    cell_data [MAX_ITEMS];

	assign req_acc   = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign full      = (cnt_q == CW'(MAX_ITEMS));

	assign new_rep.origin = req_data.origin;
	assign new_rep.seq    = req_data.seq;
	assign load_rep       = (state_q == ST_IDLE) ? new_rep : rep_q;

	// Deferral checks in their order of precedence.
	always_comb begin
		defer_hit  = 1'b1;
		defer_kind = KIND_POOL;
		priority if (req_data.pool_full) begin
			defer_kind = KIND_POOL;
		end else if (!req_data.has_route) begin
			defer_kind = KIND_NOROUTE;
		end else if (req_data.nbr_known && (req_data.nbr_fill >= cap_q)) begin
			defer_kind = KIND_NBRFULL;
		end else begin
			defer_hit = 1'b0;
		end
	end

	// Report chain: each cell loads on append at its position or shifts from its neighbor.
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		rab_cell_ctrl_t ctrl;
		rab_report_t    nbr;

		assign ctrl.load  = append && (cnt_q == CW'(i));
		assign ctrl.shift = shift;

		if (i == MAX_ITEMS - 1) begin : g_tail
			assign nbr = '0;
		end else begin : g_body
			assign nbr = cell_data[i+1];
		end

		rab_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.load_data (load_rep),
			.nbr_data  (nbr),
			.data      (cell_data[i])
		);
	end

	// Occupancy percent of the parent queue.
	rab_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (DIVIDEND_W'({7'd0, req_data.nbr_fill} * PERCENT)),
		.divisor  (cap_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Shift-based average; the arithmetic shift floors toward minus infinity.
	assign occ       = known_q ? div_quot : '0;
	assign ewma_diff = $signed({2'b00, occ}) - $signed({2'b00, ewma_q});
	assign ewma_step = ewma_diff >>> AVG_SHIFT;
	assign ewma_sum  = $signed({2'b00, ewma_q}) + ewma_step;

	// Next state and per-cycle controls.
	always_comb begin
		state_nxt = state_q;
		rsp_load  = 1'b0;
		rsp_nxt   = '0;
		shift     = 1'b0;
		append    = 1'b0;
		div_start = 1'b0;
		ewma_load = 1'b0;
		rsp_nxt.occupancy_avg = ewma_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					priority if (req_data.op == OP_ADD && !full) begin
						append = 1'b1;
					end else if (req_data.op == OP_TICK && cnt_q == '0) begin
						state_nxt = ST_IDLE;
					end else if (defer_hit) begin
						state_nxt = ST_DEFER;
					end else if (req_data.nbr_known) begin
						div_start = 1'b1;
						state_nxt = ST_DIV;
					end else begin
						state_nxt = ST_EWMA;
					end
				end
			end
			ST_DEFER: begin
				if (rsp_free) begin
					rsp_load            = 1'b1;
					rsp_nxt.kind        = kind_q;
					rsp_nxt.frame_count = 5'(cnt_q);
					rsp_nxt.last        = (op_q == OP_TICK);
					state_nxt           = (op_q == OP_TICK) ? ST_IDLE : ST_DROP;
				end
			end
			ST_DROP: begin
				if (rsp_free) begin
					rsp_load           = 1'b1;
					rsp_nxt.kind       = KIND_DROPPED;
					rsp_nxt.rep_origin = cell_data[0].origin;
					rsp_nxt.rep_seq    = cell_data[0].seq;
					rsp_nxt.last       = 1'b1;
					shift              = 1'b1;
					state_nxt          = ST_APPEND;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_nxt = ST_EWMA;
				end
			end
			ST_EWMA: begin
				ewma_load = 1'b1;
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (rsp_free) begin
					rsp_load            = 1'b1;
					rsp_nxt.kind        = KIND_FLUSHED;
					rsp_nxt.frame_count = 5'(frame_q);
					rsp_nxt.rep_origin  = cell_data[0].origin;
					rsp_nxt.rep_seq     = cell_data[0].seq;
					rsp_nxt.last        = (cnt_q == CW'(1));
					shift               = 1'b1;
					if (cnt_q == CW'(1)) begin
						state_nxt = (op_q == OP_TICK) ? ST_IDLE : ST_APPEND;
					end
				end
			end
			ST_APPEND: begin
				append    = 1'b1;
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Control registers: state, fill count, average, capacity and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			ewma_q      <= '0;
			cap_q       <= CAP_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (append) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (shift) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (ewma_load) begin
				ewma_q <= ewma_sum[6:0];
			end
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request fields kept for the rest of the step, and the result register.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_q    <= req_data.op;
			known_q <= req_data.nbr_known;
			kind_q  <= defer_kind;
			rep_q   <= new_rep;
			frame_q <= cnt_q;
		end
		if (rsp_load) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// ----- src/rab_checker.sv -----
// Port-level checks of the report aggregation buffer and their binding.
`include "assert_macros.svh"

module rab_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input rab_pkg::rab_rsp_t rsp_data
);
	import rab_pkg::*;

	// A stalled result stays offered unchanged.
	`RAB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")

	// Deferral results carry no report.
	`RAB_ASSERT(a_defer_empty, !(rsp_valid && (rsp_data.kind == KIND_POOL || rsp_data.kind == KIND_NOROUTE || rsp_data.kind == KIND_NBRFULL)) || (rsp_data.rep_origin == 8'd0 && rsp_data.rep_seq == 16'd0), "deferral carries a report")

	// A drop always ends the step and has no frame count.
	`RAB_ASSERT(a_drop_last, !(rsp_valid && rsp_data.kind == KIND_DROPPED) || (rsp_data.last && rsp_data.frame_count == 5'd0), "drop result malformed")

	// The smoothed occupancy never exceeds one hundred percent.
	`RAB_ASSERT(a_avg_range, !rsp_valid || rsp_data.occupancy_avg <= 7'd100, "average out of range")

endmodule

bind report_aggregation_buffer rab_checker u_rab_checker (.*);
